// ===== rtl/deq_pkg.sv =====
// Shared constants and types for the double-ended queue unit.
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    status_t          status;
  } ram_op_t;

endpackage

// ===== rtl/deq_ram.sv =====
// Generic single-port RAM with registered read.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/deq_ctrl.sv =====
// Front/rear index and count tracking; decides each item's RAM access and status.
module deq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  deq_pkg::req_t             req,
  output deq_pkg::ram_op_t          op,
  output logic [deq_pkg::CNT_W-1:0] count
);

  logic [deq_pkg::IDX_W-1:0] front, front_next;
  logic [deq_pkg::IDX_W-1:0] rear, rear_next;
  logic [deq_pkg::CNT_W-1:0] count_next;
  logic [deq_pkg::IDX_W-1:0] front_dec, front_inc, rear_dec, rear_inc;
  logic                      full, empty;

  localparam logic [deq_pkg::IDX_W-1:0] LAST = deq_pkg::IDX_W'(deq_pkg::DEPTH - 1);

  assign full  = (count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty = (count == '0);

  assign front_dec = (front == '0)  ? LAST : front - 1'b1;
  assign front_inc = (front == LAST) ? '0  : front + 1'b1;
  assign rear_dec  = (rear == '0)   ? LAST : rear - 1'b1;
  assign rear_inc  = (rear == LAST)  ? '0  : rear + 1'b1;

  always_comb begin
    op         = '{we: 1'b0, re: 1'b0, addr: front, status: deq_pkg::ST_OK};
    front_next = front;
    rear_next  = rear;
    count_next = count;
    unique case (req)
      deq_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          op.status = deq_pkg::ST_FULL;
        end else begin
          op.we      = 1'b1;
          op.addr    = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::REQ_PUSH_REAR: begin
        if (full) begin
          op.status = deq_pkg::ST_FULL;
        end else begin
          op.we      = 1'b1;
          op.addr    = rear;
          rear_next  = rear_inc;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          op.status = deq_pkg::ST_EMPTY;
        end else begin
          op.re      = 1'b1;
          op.addr    = front;
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      deq_pkg::REQ_POP_REAR: begin
        if (empty) begin
          op.status = deq_pkg::ST_EMPTY;
        end else begin
          op.re      = 1'b1;
          op.addr    = rear_dec;
          rear_next  = rear_dec;
          count_next = count - 1'b1;
        end
      end
      default: begin
        op.status = deq_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      op.we      = 1'b0;
      op.re      = 1'b0;
      front_next = front;
      rear_next  = rear;
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      rear  <= rear_next;
      count <= count_next;
    end
  end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: ring store, control and output stage.
// An accepted request is held in stage s1 beside the registered RAM read, then moves to the output register.
// Throughput: one item per cycle while the result side keeps taking results; the single RAM port is used once per item.
// Reads see the previous cycle's write, so back-to-back push/pop needs no forwarding.
// Reset (rst, synchronous): indices and count cleared, deque empty, no result pending.
// Store contents are not cleared; a pop only ever reads a written slot.
module double_ended_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // push_value[31:0]
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // pop_value[31:0]
  output logic [1:0]  m_tuser   // status[1:0]
);

  logic                      s_accept;
  logic                      s1_move;
  deq_pkg::ram_op_t          op;
  logic [deq_pkg::CNT_W-1:0] count;
  logic [deq_pkg::DATA_W-1:0] rdata;

  logic             s1_valid;
  logic             s1_rd;
  deq_pkg::status_t s1_status;

  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign s_accept = s_tvalid && s_tready;

  deq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (s_accept),
    .req    (deq_pkg::req_t'(s_tuser)),
    .op     (op),
    .count  (count)
  );

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (op.we),
    .re    (op.re),
    .addr  (op.addr),
    .wdata (s_tdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_rd     <= op.re;
      s1_status <= op.status;
    end
    if (s1_move) begin
      m_tdata <= s1_rd ? rdata : '0;
      m_tuser <= s1_status;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("entry count beyond capacity");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> s1_valid)
    else $error("accepted item lost before output stage");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != deq_pkg::ST_OK) |-> (m_tdata == '0))
    else $error("refused request carries nonzero data");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    s_accept && op.we |=> count == $past(count) + 1'b1)
    else $error("count not advanced on push");

endmodule

// ===== verif/double_ended_queue_unit_tb.sv =====
// Testbench for double_ended_queue_unit: directed and random requests checked against a deque mirror.
`timescale 1ns / 100ps

module double_ended_queue_unit_tb;

  typedef struct packed {
    logic [deq_pkg::DATA_W-1:0] word;
    deq_pkg::status_t           status;
  } deque_result_t;

  class deque_mirror;
    logic [deq_pkg::DATA_W-1:0] slots [deq_pkg::DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       fill;
    deque_result_t     pending_results [$];
    int unsigned       failures;

    function void record_request(deq_pkg::req_t kind, logic [deq_pkg::DATA_W-1:0] word);
      deque_result_t res;
      res.word   = '0;
      res.status = deq_pkg::ST_OK;
      case (kind) inside
        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_REAR: begin
          if (fill >= deq_pkg::DEPTH) begin
            res.status = deq_pkg::ST_FULL;
          end else if (kind == deq_pkg::REQ_PUSH_FRONT) begin
            head = (head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
            slots[head] = word;
            fill++;
          end else begin
            slots[tail] = word;
            tail = (tail + 1) % deq_pkg::DEPTH;
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            res.status = deq_pkg::ST_EMPTY;
          end else if (kind == deq_pkg::REQ_POP_FRONT) begin
            res.word = slots[head];
            head = (head + 1) % deq_pkg::DEPTH;
            fill--;
          end else begin
            tail = (tail + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
            res.word = slots[tail];
            fill--;
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void compare_result(logic [deq_pkg::DATA_W-1:0] got_word,
                                 deq_pkg::status_t got_status);
      deque_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result value=%h status=%s", $time, got_word,
                   got_status.name());
        return;
      end
      want = pending_results.pop_front();
      if (got_word !== want.word || got_status !== want.status) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch value exp=%h got=%h status exp=%s got=%s", $time,
                   want.word, got_word, want.status.name(), got_status.name());
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  deque_mirror book = new();
  int unsigned accepted   = 0;
  int unsigned cycles     = 0;
  bit          steady     = 1'b0;
  bit          hold_asked = 1'b0;

  double_ended_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("double_ended_queue_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic offer(input deq_pkg::req_t kind, input logic [31:0] word);
    if (!steady) begin
      while ($urandom_range(99) < 26) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.record_request(kind, word);
    accepted++;
    steady = (accepted >= 650 && accepted < 850);
    if (accepted == 300) hold_asked = 1'b1;
  endtask

  // result side: random stalls plus one long hold-off to back the block up
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        book.compare_result(m_tdata, deq_pkg::status_t'(m_tuser));
      if (hold_asked && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin
    logic [31:0]   corner_words [4];
    int unsigned   sent;
    int unsigned   phase_len;
    int unsigned   push_pct;
    int unsigned   wait_cycles;
    deq_pkg::req_t kind;
    logic [31:0]   word;
    corner_words[0] = 32'h8000_0000;
    corner_words[1] = 32'h7FFF_FFFF;
    corner_words[2] = 32'h0000_0000;
    corner_words[3] = 32'hFFFF_FFFF;
    sent = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // pops on empty, extremes through both ends, front index wrapping below zero
    offer(deq_pkg::REQ_POP_FRONT, $urandom);
    offer(deq_pkg::REQ_POP_REAR, $urandom);
    offer(deq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
    offer(deq_pkg::REQ_PUSH_REAR, 32'h7FFF_FFFF);
    offer(deq_pkg::REQ_POP_REAR, $urandom);
    offer(deq_pkg::REQ_POP_FRONT, $urandom);
    // fill completely, then refused pushes at both ends
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      if (i == 0) word = 32'hFFFF_FFFF;
      else if (i == 1) word = 32'h0000_0000;
      else word = $urandom;
      offer(i[0] ? deq_pkg::REQ_PUSH_REAR : deq_pkg::REQ_PUSH_FRONT, word);
    end
    offer(deq_pkg::REQ_PUSH_FRONT, $urandom);
    offer(deq_pkg::REQ_PUSH_REAR, $urandom);

    // phases biased toward filling, churning or draining
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(48, 4);
      case ($urandom_range(2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      repeat (phase_len) begin
        if ($urandom_range(99) < push_pct)
          kind = $urandom_range(1) ? deq_pkg::REQ_PUSH_REAR : deq_pkg::REQ_PUSH_FRONT;
        else
          kind = $urandom_range(1) ? deq_pkg::REQ_POP_REAR : deq_pkg::REQ_POP_FRONT;
        word = ($urandom_range(7) == 0) ? corner_words[$urandom_range(3)] : $urandom;
        offer(kind, word);
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    while (book.outstanding() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 8) begin
      @(posedge clk);
      wait_cycles++;
    end

    if (book.failures == 0 && book.outstanding() == 0) begin
      $display("double_ended_queue_unit_tb: PASS");
    end else begin
      $display("double_ended_queue_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
